>>> rtl/assert_macros.svh
// assertion macros for the rtl, used by arithmetic_interval_encoder_top
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

>>> rtl/aie_pkg.sv
// shared constants for the arithmetic interval encoder
// no dependencies
package aie_pkg;

   // results a single request may produce before renormalization stops
   localparam int unsigned MAX_RESULTS = 16;
   localparam int unsigned RES_CNT_W   = 5;

   // width and saturation limit of the pending-bit counter
   localparam int unsigned PEND_W = 16;

endpackage

>>> rtl/arithmetic_interval_encoder_top.sv
// arithmetic interval encoder: divider, serial multiplier and renormalizer
// depends on aie_pkg and assert_macros.svh
//
// channel   dir  handshake             payload
// req_      in   req_valid/req_ready   cum_low, cum_high, total_freq
// rsp_      out  rsp_valid/rsp_ready   lead_bit, follow_count, last
//
// one request: the accept cycle, a restoring divide (one quotient bit per cycle) that
// yields PRECISION+1 quotient bits, a shift-add multiply over the FREQ_BITS frequency
// bits, a clamp step, the renormalization steps one at a time and a final step
// the single subtract/compare unit and the serial adders set this step-by-step pace
// reset (synchronous, active high): low zero, high all ones, pending zero, req_ready high
// req_ready is low while a request is coded; a stalled rsp_ready holds the shift steps
`include "assert_macros.svh"

module arithmetic_interval_encoder_top #(
   parameter int unsigned PRECISION = 16,
   parameter int unsigned FREQ_BITS = 14
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [FREQ_BITS-1:0]        req_cum_low,
   input  logic [FREQ_BITS-1:0]        req_cum_high,
   input  logic [FREQ_BITS-1:0]        req_total_freq,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_lead_bit,
   output logic [aie_pkg::PEND_W-1:0]  rsp_follow_count,
   output logic                        rsp_last
);

   localparam int unsigned P  = PRECISION;
   localparam int unsigned F  = FREQ_BITS;
   localparam int unsigned QW = P + 1;
   localparam int unsigned MW = (QW > F) ? QW : F;
   localparam int unsigned PW = MW + 1;
   localparam int unsigned SW = PW + 1;
   localparam int unsigned CW = $clog2(MW);
   localparam int unsigned NW = aie_pkg::RES_CNT_W;
   localparam int unsigned PN = aie_pkg::PEND_W;

   typedef enum logic [2:0] {
      IDLE,
      DIVIDE,
      MULTIPLY,
      CLAMP,
      RENORM
   } state_type;

   state_type         state_ff;
   logic [F-1:0]      cl_ff, ch_ff, t_ff;
   logic [F:0]        rem_ff;
   logic [QW-1:0]     quo_ff;
   logic [CW-1:0]     cnt_ff;
   logic [PW-1:0]     acc_l_ff, acc_h_ff;
   logic [P-1:0]      lo_ff, hi_ff;
   logic [PN-1:0]     pend_ff;
   logic [NW-1:0]     nres_ff;
   logic              hold_valid_ff, hold_bit_ff;
   logic [PN-1:0]     hold_cnt_ff;
   logic              rsp_valid_ff, rsp_bit_ff, rsp_last_ff;
   logic [PN-1:0]     rsp_cnt_ff;

   // request clamping
   logic [F-1:0] t_fix, ch_lim, ch_fix, cl_fix;
   always_comb begin
      t_fix  = (req_total_freq == '0) ? F'(1) : req_total_freq;
      ch_lim = (req_cum_high > t_fix) ? t_fix : req_cum_high;
      ch_fix = (ch_lim == '0) ? F'(1) : ch_lim;
      cl_fix = (req_cum_low >= ch_fix) ? (ch_fix - F'(1)) : req_cum_low;
   end

   // interval width at request time
   logic [P-1:0]  hi_eff;
   logic [QW-1:0] range_w;
   assign hi_eff  = (hi_ff < lo_ff) ? lo_ff : hi_ff;
   assign range_w = {1'b0, hi_eff} - {1'b0, lo_ff} + QW'(1);

   // restoring divider step
   logic [F:0]    rem_sh, rem_sub;
   logic          div_ge;
   logic [QW-1:0] quo_in;
   assign rem_sh  = {rem_ff[F-1:0], quo_ff[QW-1]};
   assign div_ge  = rem_sh >= {1'b0, t_ff};
   assign rem_sub = rem_sh - {1'b0, t_ff};
   assign quo_in  = {quo_ff[QW-2:0], div_ge};

   // shift-add multiplier step, msb of the frequency first
   logic [PW-1:0] s_ext, acc_l_in, acc_h_in;
   assign s_ext    = {{(PW-QW){1'b0}}, quo_ff};
   assign acc_l_in = {acc_l_ff[PW-2:0], 1'b0} + (cl_ff[F-1] ? s_ext : '0);
   assign acc_h_in = {acc_h_ff[PW-2:0], 1'b0} + (ch_ff[F-1] ? s_ext : '0);

   // new interval bounds, clamped to the old high
   logic [SW-1:0] lo_ext, hi_ext, nl_sum, nh_sum;
   logic [P-1:0]  nl_c, nh_c;
   always_comb begin
      lo_ext = {{(SW-P){1'b0}}, lo_ff};
      hi_ext = {{(SW-P){1'b0}}, hi_ff};
      nl_sum = lo_ext + {1'b0, acc_l_ff};
      nh_sum = lo_ext + {1'b0, acc_h_ff} - SW'(1);
      nl_c   = (nl_sum > hi_ext) ? hi_ff : nl_sum[P-1:0];
      nh_c   = (nh_sum > hi_ext) ? hi_ff : nh_sum[P-1:0];
   end

   // renormalization case decode
   logic is_low, is_high, is_mid, is_shift, out_free, res_full;
   logic renorm_done, rsp_load;
   assign is_low      = !hi_ff[P-1];
   assign is_high     = lo_ff[P-1];
   assign is_mid      = (lo_ff[P-1:P-2] == 2'b01) && (hi_ff[P-1:P-2] == 2'b10);
   assign is_shift    = is_low || is_high;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign res_full    = (nres_ff == NW'(aie_pkg::MAX_RESULTS));
   assign renorm_done = res_full || !(is_shift || is_mid);
   // held result moves to the output register this cycle
   assign rsp_load    = (state_ff == RENORM) && hold_valid_ff && out_free &&
                        (renorm_done || is_shift);

   // sequencer, interval state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         lo_ff         <= '0;
         hi_ff         <= '1;
         pend_ff       <= '0;
         nres_ff       <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (req_valid) begin
                  cl_ff    <= cl_fix;
                  ch_ff    <= ch_fix;
                  t_ff     <= t_fix;
                  hi_ff    <= hi_eff;
                  quo_ff   <= range_w;
                  rem_ff   <= '0;
                  cnt_ff   <= CW'(P);
                  state_ff <= DIVIDE;
               end
            end
            DIVIDE: begin
               rem_ff <= div_ge ? rem_sub : rem_sh;
               if (cnt_ff == '0) begin
                  // a zero step unit counts as one
                  quo_ff   <= (quo_in == '0) ? QW'(1) : quo_in;
                  acc_l_ff <= '0;
                  acc_h_ff <= '0;
                  cnt_ff   <= CW'(F - 1);
                  state_ff <= MULTIPLY;
               end else begin
                  quo_ff <= quo_in;
                  cnt_ff <= cnt_ff - CW'(1);
               end
            end
            MULTIPLY: begin
               acc_l_ff <= acc_l_in;
               acc_h_ff <= acc_h_in;
               cl_ff    <= {cl_ff[F-2:0], 1'b0};
               ch_ff    <= {ch_ff[F-2:0], 1'b0};
               cnt_ff   <= cnt_ff - CW'(1);
               if (cnt_ff == '0) begin
                  state_ff <= CLAMP;
               end
            end
            CLAMP: begin
               lo_ff    <= nl_c;
               hi_ff    <= nh_c;
               nres_ff  <= '0;
               state_ff <= RENORM;
            end
            RENORM: begin
               if (renorm_done) begin
                  // done: flush the held result as the last one
                  if (!hold_valid_ff) begin
                     state_ff <= IDLE;
                  end else if (out_free) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_bit_ff    <= hold_bit_ff;
                     rsp_cnt_ff    <= hold_cnt_ff;
                     rsp_last_ff   <= 1'b1;
                     hold_valid_ff <= 1'b0;
                     state_ff      <= IDLE;
                  end
               end else if (is_shift) begin
                  // lower or upper half: both reduce to a plain shift
                  if (!hold_valid_ff || out_free) begin
                     if (hold_valid_ff) begin
                        rsp_valid_ff <= 1'b1;
                        rsp_bit_ff   <= hold_bit_ff;
                        rsp_cnt_ff   <= hold_cnt_ff;
                        rsp_last_ff  <= 1'b0;
                     end
                     hold_valid_ff <= 1'b1;
                     hold_bit_ff   <= is_high;
                     hold_cnt_ff   <= pend_ff;
                     pend_ff       <= '0;
                     nres_ff       <= nres_ff + NW'(1);
                     lo_ff         <= {lo_ff[P-2:0], 1'b0};
                     hi_ff         <= {hi_ff[P-2:0], 1'b1};
                  end
               end else begin
                  // middle quarter: drop the second bit, saturate pending
                  lo_ff <= {1'b0, lo_ff[P-3:0], 1'b0};
                  hi_ff <= {1'b1, hi_ff[P-3:0], 1'b1};
                  if (pend_ff != '1) begin
                     pend_ff <= pend_ff + PN'(1);
                  end
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign req_ready        = (state_ff == IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_lead_bit     = rsp_bit_ff;
   assign rsp_follow_count = rsp_cnt_ff;
   assign rsp_last         = rsp_last_ff;

   // checks
   `ASSERT_IMPLIES(a_idle_no_hold, clock, reset, req_ready, !hold_valid_ff)
   `ASSERT_IMPLIES(a_res_bound, clock, reset, 1'b1, nres_ff <= NW'(aie_pkg::MAX_RESULTS))
   `ASSERT_IMPLIES(a_interval_order, clock, reset, state_ff == IDLE, lo_ff <= hi_ff)
   `ASSERT_NEXT(a_clamp_order, clock, reset, state_ff == CLAMP, lo_ff <= hi_ff)

endmodule

>>> tb/sv/arithmetic_interval_encoder_top_tb.sv
// self-checking testbench for arithmetic_interval_encoder_top: a stimulus table,
// then random symbols under several idling mixes, each checked against a local coder
// depends on aie_pkg and the encoder rtl
`timescale 1ns / 100ps

module arithmetic_interval_encoder_top_tb;

   localparam int FREQ_W       = 14;
   localparam int IV_W         = 16;
   localparam int PEND_W       = aie_pkg::PEND_W;
   localparam bit [IV_W-1:0] IV_HALF     = 16'h8000;
   localparam bit [IV_W-1:0] IV_QUARTER  = 16'h4000;
   localparam bit [IV_W-1:0] IV_3QUARTER = 16'hC000;
   localparam int PREDICTED    = -1;
   localparam int RANDOM_ITEMS = 76;
   localparam int TAIL_CYCLES  = 200;
   localparam int IDLE_LIMIT   = 4000;
   localparam int NUM_PHASES   = 4;
   localparam int GAP_PCT   [NUM_PHASES] = '{0, 76, 0, 28};
   localparam int STALL_PCT [NUM_PHASES] = '{0, 0, 76, 28};

   typedef struct packed {
      bit              lead_bit;
      bit [PEND_W-1:0] follow_count;
      bit              last;
   } coded_bit_type;

   // one table row: a symbol, how often to send it, and an optional typed result
   typedef struct packed {
      bit [FREQ_W-1:0] cum_low;
      bit [FREQ_W-1:0] cum_high;
      bit [FREQ_W-1:0] total_freq;
      int              reps;
      int              typed_count;
      bit              exp_lead;
      bit [PEND_W-1:0] exp_follow;
   } symbol_row_type;

   localparam int NUM_ROWS = 20;
   localparam symbol_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      // from the reset interval: one lower shift, one upper shift
      '{14'd0,     14'd1,     14'd2,     1,    1,         1'b0, 16'd0},
      '{14'd1,     14'd2,     14'd2,     1,    1,         1'b1, 16'd0},
      // full-range symbol and zero total: nothing to shift
      '{14'd0,     14'd1,     14'd1,     1,    0,         1'b0, 16'd0},
      '{14'd0,     14'd0,     14'd0,     1,    0,         1'b0, 16'd0},
      // middle quarter only, then a lower shift carrying one pending bit
      '{14'd1,     14'd3,     14'd4,     1,    0,         1'b0, 16'd0},
      '{14'd0,     14'd1,     14'd2,     1,    1,         1'b0, 16'd1},
      // centered symbol adds 13 pending bits each time, then a lower shift
      '{14'd8191,  14'd8193,  14'd16383, 5,    PREDICTED, 1'b0, 16'd0},
      '{14'd0,     14'd1,     14'd2,     1,    1,         1'b0, 16'd65},
      // field extremes and out-of-order frequencies
      '{14'd16383, 14'd16383, 14'd16383, 1,    PREDICTED, 1'b0, 16'd0},
      '{14'd0,     14'd1,     14'd16383, 1,    PREDICTED, 1'b0, 16'd0},
      '{14'd5,     14'd16383, 14'd10,    1,    PREDICTED, 1'b0, 16'd0},
      '{14'd9000,  14'd100,   14'd16383, 1,    PREDICTED, 1'b0, 16'd0},
      '{14'd16383, 14'd0,     14'd16383, 1,    PREDICTED, 1'b0, 16'd0},
      '{14'd0,     14'd16383, 14'd16383, 1,    PREDICTED, 1'b0, 16'd0},
      // narrow symbols, most at a large total, long shift runs; one zero total
      '{14'd16382, 14'd16383, 14'd16383, 1,    PREDICTED, 1'b0, 16'd0},
      '{14'd8192,  14'd8193,  14'd16383, 1,    PREDICTED, 1'b0, 16'd0},
      '{14'd3,     14'd16383, 14'd0,     1,    PREDICTED, 1'b0, 16'd0},
      '{14'd12345, 14'd12346, 14'd16383, 1,    PREDICTED, 1'b0, 16'd0},
      '{14'd1,     14'd2,     14'd3,     1,    PREDICTED, 1'b0, 16'd0},
      '{14'd10922, 14'd10923, 14'd16383, 1,    PREDICTED, 1'b0, 16'd0}
   };

   logic              clock;
   logic              reset          = 1'b1;
   logic              req_valid      = 1'b0;
   logic              req_ready;
   logic [FREQ_W-1:0] req_cum_low    = '0;
   logic [FREQ_W-1:0] req_cum_high   = '0;
   logic [FREQ_W-1:0] req_total_freq = '0;
   logic              rsp_valid;
   logic              rsp_ready      = 1'b0;
   logic              rsp_lead_bit;
   logic [PEND_W-1:0] rsp_follow_count;
   logic              rsp_last;

   // coder state mirrored by the testbench
   bit [IV_W-1:0]   iv_low;
   bit [IV_W-1:0]   iv_high;
   bit [PEND_W-1:0] pend_count;

   coded_bit_type expected_bits_q [$];
   int         gap_pct    = 0;
   int         stall_pct  = 0;
   int         err_count  = 0;
   int         rsp_count  = 0;
   int         idle_cycles = 0;

   arithmetic_interval_encoder_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cum_low      (req_cum_low),
      .req_cum_high     (req_cum_high),
      .req_total_freq   (req_total_freq),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_lead_bit     (rsp_lead_bit),
      .rsp_follow_count (rsp_follow_count),
      .rsp_last         (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_error(input string msg);
      $display("error at response %0d: %s", rsp_count, msg);
      err_count++;
   endtask

   // append one expected bit at the tail of the queue
   function automatic void queue_expected(input bit lead, input bit [PEND_W-1:0] follow,
                                          input bit is_last);
      coded_bit_type item;
      item.lead_bit     = lead;
      item.follow_count = follow;
      item.last         = is_last;
      expected_bits_q   = {expected_bits_q, item};
   endfunction

   // narrow the interval to the symbol, renormalize, queue the emitted bits
   function automatic int code_symbol(input bit [FREQ_W-1:0] cl_in, ch_in, tot_in);
      bit [FREQ_W-1:0] tot;
      bit [FREQ_W-1:0] ch;
      bit [FREQ_W-1:0] cl;
      bit [IV_W-1:0]   lo;
      bit [IV_W-1:0]   hi;
      bit [IV_W:0]     span;
      bit [IV_W:0]     unit;
      bit [31:0]       new_low;
      bit [31:0]       new_high;
      int              n;
      tot = (tot_in == 0) ? FREQ_W'(1) : tot_in;
      ch  = (ch_in > tot) ? tot : ch_in;
      if (ch == 0) ch = FREQ_W'(1);
      cl  = (cl_in >= ch) ? ch - 1'b1 : cl_in;
      lo  = iv_low;
      hi  = (iv_high < iv_low) ? iv_low : iv_high;
      span = {1'b0, hi} - {1'b0, lo} + 1'b1;
      unit = span / tot;
      if (unit == 0) unit = {{IV_W{1'b0}}, 1'b1};
      new_low  = 32'(lo) + 32'(unit) * 32'(cl);
      new_high = 32'(lo) + 32'(unit) * 32'(ch) - 32'd1;
      lo = (new_low > 32'(hi)) ? hi : new_low[IV_W-1:0];
      hi = (new_high > 32'(hi)) ? hi : new_high[IV_W-1:0];
      n = 0;
      while (n < int'(aie_pkg::MAX_RESULTS)) begin
         if (hi < IV_HALF) begin
            queue_expected(1'b0, pend_count, 1'b0);
            pend_count = '0;
            n++;
            lo = lo << 1;
            hi = (hi << 1) | 1'b1;
         end else if (lo >= IV_HALF) begin
            queue_expected(1'b1, pend_count, 1'b0);
            pend_count = '0;
            n++;
            lo = (lo - IV_HALF) << 1;
            hi = ((hi - IV_HALF) << 1) | 1'b1;
         end else if (lo >= IV_QUARTER && hi < IV_3QUARTER) begin
            lo = (lo - IV_QUARTER) << 1;
            hi = ((hi - IV_QUARTER) << 1) | 1'b1;
            if (pend_count != '1) pend_count++;
         end else begin
            break;
         end
      end
      if (n > 0) expected_bits_q[$].last = 1'b1;
      iv_low  = lo;
      iv_high = hi;
      return n;
   endfunction

   // random symbol: mostly well-formed, some narrow or centered, some raw noise
   function automatic void draw_symbol(output bit [FREQ_W-1:0] cl, ch, tot);
      int pick;
      int sel;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         sel = $urandom_range(0, 3);
         if (sel < 2) tot = FREQ_W'($urandom_range(1, 16383));
         else if (sel == 2) tot = FREQ_W'($urandom_range(8192, 16383));
         else tot = FREQ_W'($urandom_range(1, 32));
         ch = FREQ_W'($urandom_range(1, tot));
         cl = FREQ_W'($urandom_range(0, ch - 1));
      end else if (pick < 60) begin
         tot = FREQ_W'($urandom_range(12000, 16383));
         cl  = FREQ_W'($urandom_range(0, tot - 1));
         ch  = cl + 1'b1;
      end else if (pick < 75) begin
         tot = 14'd16383;
         cl  = FREQ_W'($urandom_range(8188, 8192));
         ch  = cl + FREQ_W'($urandom_range(1, 4));
      end else begin
         cl  = FREQ_W'($urandom_range(0, 16383));
         ch  = FREQ_W'($urandom_range(0, 16383));
         tot = FREQ_W'($urandom_range(0, 16383));
      end
   endfunction

   // present one request, hold it until accepted, then predict its bits
   task automatic send_symbol(input bit [FREQ_W-1:0] cl, ch, tot, output int n_coded);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cum_low    <= cl;
      req_cum_high   <= ch;
      req_total_freq <= tot;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      n_coded = code_symbol(cl, ch, tot);
   endtask

   // receiver stalls
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // compare each accepted response with the oldest expected bit
   always @(posedge clock) begin
      coded_bit_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bits_q.size() == 0) begin
            report_error($sformatf("unexpected response lead_bit=%0b follow_count=%0d",
                                   rsp_lead_bit, rsp_follow_count));
         end else begin
            want = expected_bits_q.pop_front();
            if (rsp_lead_bit !== want.lead_bit)
               report_error($sformatf("lead_bit got %0b expected %0b",
                                      rsp_lead_bit, want.lead_bit));
            if (rsp_follow_count !== want.follow_count)
               report_error($sformatf("follow_count got %0d expected %0d",
                                      rsp_follow_count, want.follow_count));
            if (rsp_last !== want.last)
               report_error($sformatf("last got %0b expected %0b", rsp_last, want.last));
         end
         rsp_count++;
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      symbol_row_type  row;
      bit [FREQ_W-1:0] cl;
      bit [FREQ_W-1:0] ch;
      bit [FREQ_W-1:0] tot;
      int              n_coded;
      iv_low     = '0;
      iv_high    = '1;
      pend_count = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (DIRECTED_ROWS[i]) begin
         row = DIRECTED_ROWS[i];
         repeat (row.reps) begin
            send_symbol(row.cum_low, row.cum_high, row.total_freq, n_coded);
            // typed rows replace the predicted bits with the known answer
            if (row.typed_count != PREDICTED) begin
               repeat (n_coded) void'(expected_bits_q.pop_back());
               if (row.typed_count == 1)
                  queue_expected(row.exp_lead, row.exp_follow, 1'b1);
            end
         end
      end

      // random symbols under each idling mix
      for (int p = 0; p < NUM_PHASES; p++) begin
         gap_pct   = GAP_PCT[p];
         stall_pct = STALL_PCT[p];
         repeat (RANDOM_ITEMS) begin
            draw_symbol(cl, ch, tot);
            send_symbol(cl, ch, tot, n_coded);
         end
      end
      req_valid <= 1'b0;

      // drain, then give a trailing zero-result request time to finish
      while (expected_bits_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (err_count == 0 && expected_bits_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/aie_pkg.sv
rtl/arithmetic_interval_encoder_top.sv
tb/sv/arithmetic_interval_encoder_top_tb.sv
